FILE: rtl/core/lhs_pkg.sv
// Shared constants, types and helpers of the landmark heatmap splatter.
`timescale 1ns / 1ps
package lhs_pkg;

    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 128;
    localparam int FRAC_BITS   = 6;
    localparam int MAX_RADIUS  = 15;

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int MAX_DIM     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    // Window coordinates may run past the image by up to one radius.
    localparam int COORD_W     = $clog2(MAX_DIM + 2 * MAX_RADIUS + 2);
    localparam int LX_W        = COORD_W + FRAC_BITS;
    localparam int CLIP_W      = LX_W + 2;

    // Offset from pixel to landmark, squared distance and root.
    localparam int D_W         = $clog2((MAX_RADIUS + 1) << FRAC_BITS) + 1;
    localparam int Q_W         = 2 * D_W;
    localparam int SQ_IN_W     = Q_W + 16;
    localparam int ROOT_W      = SQ_IN_W / 2;
    localparam int SREM_W      = ROOT_W + 3;
    localparam int DEN_W       = ROOT_W + 1;
    localparam int DREM_W      = DEN_W + 1;
    localparam int NUM_W       = 15 + FRAC_BITS + 9;
    localparam int QUO_W       = 17;
    localparam int CNT_W       = $clog2(ROOT_W + 1);

    localparam logic [DEN_W-1:0] ONE_FX     = DEN_W'(1) << (FRAC_BITS + 8);
    localparam logic [NUM_W-1:0] NUM_BASE   = NUM_W'(32768) << (FRAC_BITS + 8);
    localparam logic [15:0]      VALUE_ONE  = 16'd32768;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_DRAW  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_DRAW,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [LX_W-1:0]    lx;
        logic [LX_W-1:0]    ly;
        logic [ADDR_W-1:0]  addr;
        logic               rd_zero;
    } t_cmd;

    // Active dimension: the register value, capped at the store size.
    function automatic logic [COORD_W-1:0] active_dim(input logic [7:0] cfg,
                                                      input int unsigned lim);
        logic [COORD_W-1:0] v;
        v = COORD_W'(cfg);
        if (v > COORD_W'(lim)) begin
            v = COORD_W'(lim);
        end
        return v;
    endfunction

endpackage

FILE: rtl/core/lhs_front.sv
// Front end: accepts requests, clips landmarks and forms queue commands.
`timescale 1ns / 1ps
module lhs_front import lhs_pkg::*; (
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_func,
    input  logic signed [14:0]  i_mark_x,
    input  logic signed [14:0]  i_mark_y,
    input  logic [6:0]          i_read_col,
    input  logic [6:0]          i_read_row,
    input  logic [3:0]          i_radius,
    input  logic [COORD_W-1:0]  i_w_act,
    input  logic [COORD_W-1:0]  i_h_act,
    input  logic                i_full,
    input  logic                i_init_done,
    output logic                o_push,
    output t_cmd                o_cmd
);

    logic signed [CLIP_W-1:0] lx_c;
    logic signed [CLIP_W-1:0] ly_c;
    logic                     useful;

    function automatic logic signed [CLIP_W-1:0] clip(input logic signed [14:0] v,
                                                     input logic [3:0] r,
                                                     input logic [COORD_W-1:0] size);
        logic signed [CLIP_W-1:0] lo;
        logic signed [CLIP_W-1:0] hi;
        logic signed [CLIP_W-1:0] m;
        lo = $signed(CLIP_W'(r) << FRAC_BITS);
        hi = $signed((CLIP_W'(size) - CLIP_W'(r) - CLIP_W'(1)) << FRAC_BITS);
        m  = CLIP_W'(v);
        if (hi < lo) begin
            hi = lo;
        end
        if (m < lo) begin
            m = lo;
        end
        if (m > hi) begin
            m = hi;
        end
        return m;
    endfunction

    assign lx_c = clip(i_mark_x, i_radius, i_w_act);
    assign ly_c = clip(i_mark_y, i_radius, i_h_act);

    always_comb begin
        o_cmd         = '0;
        o_cmd.lx      = LX_W'(lx_c);
        o_cmd.ly      = LX_W'(ly_c);
        o_cmd.addr    = ADDR_W'(ADDR_W'(i_read_row) * ADDR_W'(MAX_WIDTH))
                        + ADDR_W'(i_read_col);
        o_cmd.rd_zero = !((COORD_W'(i_read_col) < i_w_act)
                          && (COORD_W'(i_read_row) < i_h_act));
        useful        = 1'b0;
        case (i_func)
            FUNC_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                useful   = 1'b1;
            end
            FUNC_DRAW: begin
                o_cmd.op = OP_DRAW;
                // An empty image takes no pixels at all.
                useful   = (i_w_act != '0) && (i_h_act != '0);
            end
            FUNC_READ: begin
                o_cmd.op = OP_READ;
                useful   = 1'b1;
            end
            default: begin
                o_cmd.op = OP_READ;
                useful   = 1'b0;
            end
        endcase
    end

    assign o_ready = !i_full && i_init_done;
    assign o_push  = i_valid && o_ready && useful;

endmodule

FILE: rtl/core/lhs_cmd_fifo.sv
// Short command queue between the front end and the render engine.
`timescale 1ns / 1ps
module lhs_cmd_fifo import lhs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_cmd  o_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [PTR_W:0]     r_count;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
        end
    end

endmodule

FILE: rtl/core/lhs_back.sv
// Render engine: frame store, clear sweep, window walk, root and reciprocal units.
`timescale 1ns / 1ps
module lhs_back import lhs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_pop,
    input  logic [3:0]          i_radius,
    input  logic [COORD_W-1:0]  i_w_act,
    input  logic [COORD_W-1:0]  i_h_act,
    output logic                o_init_done,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [15:0]         o_pixel_value
);

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_PIX,
        B_SUM,
        B_SQRT,
        B_DIV,
        B_WRITE,
        B_READ
    } t_state;

    t_state                 r_state;
    logic                   r_init_done;
    logic [15:0]            r_mem [STORE_DEPTH];
    logic [15:0]            r_rdata;
    logic [ADDR_W-1:0]      r_addr;
    logic                   r_rd_zero;
    logic [LX_W-1:0]        r_lx;
    logic [LX_W-1:0]        r_ly;
    logic [COORD_W-1:0]     r_x;
    logic [COORD_W-1:0]     r_y;
    logic [COORD_W-1:0]     r_xs;
    logic [COORD_W-1:0]     r_xe;
    logic [COORD_W-1:0]     r_ye;
    logic [Q_W-1:0]         r_sqx;
    logic [Q_W-1:0]         r_sqy;
    logic [SQ_IN_W-1:0]     r_sv;
    logic [ROOT_W-1:0]      r_root;
    logic [SREM_W-1:0]      r_srem;
    logic [DEN_W-1:0]       r_den;
    logic [DREM_W-1:0]      r_drem;
    logic [QUO_W-1:0]       r_dnum;
    logic [QUO_W-1:0]       r_quo;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_out_valid;
    logic [15:0]            r_out_value;

    logic [ADDR_W-1:0]      raddr;
    logic                   we;
    logic [15:0]            wdata;
    logic signed [D_W-1:0]  dx;
    logic signed [D_W-1:0]  dy;
    logic signed [Q_W-1:0]  px;
    logic signed [Q_W-1:0]  py;
    logic [ADDR_W-1:0]      pix_addr;
    logic [SREM_W-1:0]      s_sh;
    logic [SREM_W-1:0]      s_trial;
    logic [DEN_W-1:0]       den_n;
    logic [NUM_W-1:0]       num_n;
    logic [DREM_W-1:0]      d_sh;
    logic [15:0]            val;
    logic [COORD_W-1:0]     ix;
    logic [COORD_W-1:0]     iy;
    logic                   out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = (r_state == B_IDLE) && i_cmd_valid;

    assign ix = COORD_W'(i_cmd.lx >> FRAC_BITS);
    assign iy = COORD_W'(i_cmd.ly >> FRAC_BITS);

    assign dx = D_W'($signed({2'b00, r_x, {FRAC_BITS{1'b0}}}) - $signed({2'b00, r_lx}));
    assign dy = D_W'($signed({2'b00, r_y, {FRAC_BITS{1'b0}}}) - $signed({2'b00, r_ly}));
    assign px = dx * dx;
    assign py = dy * dy;
    assign pix_addr = ADDR_W'(ADDR_W'(r_y) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(r_x);

    // One root digit per step, two radicand bits at a time.
    assign s_sh    = {r_srem[SREM_W-3:0], r_sv[SQ_IN_W-1 -: 2]};
    assign s_trial = SREM_W'({r_root, 2'b01});

    assign den_n = ONE_FX + DEN_W'(r_root);
    assign num_n = NUM_BASE + NUM_W'(den_n >> 1);

    // One quotient bit per step.
    assign d_sh = {r_drem[DREM_W-2:0], r_dnum[QUO_W-1]};

    assign val = (r_quo > QUO_W'(VALUE_ONE)) ? VALUE_ONE : 16'(r_quo);

    always_comb begin
        raddr = r_addr;
        if (r_state == B_IDLE) begin
            raddr = i_cmd.addr;
        end
        we    = 1'b0;
        wdata = '0;
        case (r_state)
            B_CLEAR: begin
                we = 1'b1;
            end
            B_WRITE: begin
                we    = (val > r_rdata);
                wdata = val;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_addr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_init_done <= 1'b0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !((r_state == B_READ) && out_free)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                        r_state     <= B_IDLE;
                        r_init_done <= 1'b1;
                    end
                end
                B_IDLE: begin
                    if (i_cmd_valid) begin
                        r_lx      <= i_cmd.lx;
                        r_ly      <= i_cmd.ly;
                        r_addr    <= (i_cmd.op == OP_CLEAR) ? '0 : i_cmd.addr;
                        r_rd_zero <= i_cmd.rd_zero;
                        r_x       <= ix - COORD_W'(i_radius);
                        r_xs      <= ix - COORD_W'(i_radius);
                        r_xe      <= ix + COORD_W'(i_radius);
                        r_y       <= iy - COORD_W'(i_radius);
                        r_ye      <= iy + COORD_W'(i_radius);
                        case (i_cmd.op)
                            OP_CLEAR: r_state <= B_CLEAR;
                            OP_DRAW:  r_state <= B_PIX;
                            OP_READ:  r_state <= B_READ;
                            default:  r_state <= B_IDLE;
                        endcase
                    end
                end
                B_PIX: begin
                    if (r_y > r_ye) begin
                        r_state <= B_IDLE;
                    end else if (r_x > r_xe) begin
                        r_x <= r_xs;
                        r_y <= r_y + 1'b1;
                    end else if ((r_x < i_w_act) && (r_y < i_h_act)) begin
                        r_sqx   <= Q_W'($unsigned(px));
                        r_sqy   <= Q_W'($unsigned(py));
                        r_addr  <= pix_addr;
                        r_state <= B_SUM;
                    end else begin
                        r_x <= r_x + 1'b1;
                    end
                end
                B_SUM: begin
                    r_sv    <= {r_sqx + r_sqy, 16'd0};
                    r_root  <= '0;
                    r_srem  <= '0;
                    r_cnt   <= CNT_W'(ROOT_W - 1);
                    r_state <= B_SQRT;
                end
                B_SQRT: begin
                    r_sv <= r_sv << 2;
                    if (s_sh >= s_trial) begin
                        r_srem <= s_sh - s_trial;
                        r_root <= {r_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_srem <= s_sh;
                        r_root <= {r_root[ROOT_W-2:0], 1'b0};
                    end
                    if (r_cnt == '0) begin
                        r_state <= B_DIV;
                        r_cnt   <= CNT_W'(QUO_W);
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                B_DIV: begin
                    if (r_cnt == CNT_W'(QUO_W)) begin
                        // Load the divider; the leading part of the dividend
                        // lies below the divisor.
                        r_den  <= den_n;
                        r_drem <= DREM_W'(num_n >> QUO_W);
                        r_dnum <= QUO_W'(num_n);
                        r_quo  <= '0;
                        r_cnt  <= r_cnt - 1'b1;
                    end else begin
                        r_dnum <= r_dnum << 1;
                        if (d_sh >= DREM_W'(r_den)) begin
                            r_drem <= d_sh - DREM_W'(r_den);
                            r_quo  <= {r_quo[QUO_W-2:0], 1'b1};
                        end else begin
                            r_drem <= d_sh;
                            r_quo  <= {r_quo[QUO_W-2:0], 1'b0};
                        end
                        if (r_cnt == '0) begin
                            r_state <= B_WRITE;
                        end else begin
                            r_cnt <= r_cnt - 1'b1;
                        end
                    end
                end
                B_WRITE: begin
                    r_x     <= r_x + 1'b1;
                    r_state <= B_PIX;
                end
                B_READ: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_rd_zero ? 16'd0 : r_rdata;
                        r_state     <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    assign o_init_done   = r_init_done;
    assign o_valid       = r_out_valid;
    assign o_pixel_value = r_out_value;

endmodule

FILE: rtl/core/landmark_heatmap_splatter_unit.sv
// Top level of the landmark heatmap splatter: configuration registers and wiring.
`timescale 1ns / 1ps
// The unit renders landmark heatmaps into a 128 x 128 store of Q1.15 pixels.
// A request carries a function code: clear zeroes the store, draw splats one
// landmark (signed, six fraction bits) as 1/(1+d) over the square window of
// the configured radius keeping the larger of old and new values, read returns
// one pixel on the output channel, and code three is accepted and ignored.
// The front end clips the landmark and places each request with work to do
// in a two-entry queue, so requests keep flowing in while the engine works
// and while a read result waits in the output register, until the queue is
// full. The engine handles one request at a time. A clear writes one store
// entry per cycle. A draw visits each window pixel inside the image in turn
// (square, sum, 19 root steps, one divider load, 17 reciprocal steps,
// write), and also steps past each window position outside the image, each
// window row end and a final check. A read waits in the read state while
// an earlier result still sits in the output register. After reset the same
// clearing sweep runs; no request is taken until it ends, while
// configuration writes are taken at all times. Configuration should be
// written only when the unit is idle.
module landmark_heatmap_splatter_unit import lhs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_func,
    input  logic signed [14:0]  i_mark_x,
    input  logic signed [14:0]  i_mark_y,
    input  logic [6:0]          i_read_col,
    input  logic [6:0]          i_read_row,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [15:0]         o_pixel_value,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data
);

    logic [3:0]         r_radius;
    logic [7:0]         r_width;
    logic [7:0]         r_height;
    logic [COORD_W-1:0] w_act;
    logic [COORD_W-1:0] h_act;
    logic               push;
    logic               full;
    logic               pop;
    logic               cmd_valid;
    logic               init_done;
    t_cmd               front_cmd;
    t_cmd               head_cmd;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 4'd2;
            r_width  <= 8'd112;
            r_height <= 8'd112;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RADIUS: r_radius <= i_cfg_data[3:0];
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default:    r_radius <= r_radius;
            endcase
        end
    end

    // The active image never reaches past the store.
    assign w_act = active_dim(r_width, MAX_WIDTH);
    assign h_act = active_dim(r_height, MAX_HEIGHT);

    lhs_front u_front (
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_mark_x    (i_mark_x),
        .i_mark_y    (i_mark_y),
        .i_read_col  (i_read_col),
        .i_read_row  (i_read_row),
        .i_radius    (r_radius),
        .i_w_act     (w_act),
        .i_h_act     (h_act),
        .i_full      (full),
        .i_init_done (init_done),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    lhs_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .o_valid (cmd_valid),
        .i_pop   (pop),
        .o_cmd   (head_cmd)
    );

    lhs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .i_radius      (r_radius),
        .i_w_act       (w_act),
        .i_h_act       (h_act),
        .o_init_done   (init_done),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_value (o_pixel_value)
    );

endmodule

FILE: sim/landmark_heatmap_splatter_unit_tb.sv
// Self-checking testbench of the landmark heatmap splatter unit.
`timescale 1ns / 1ps
// The bench keeps its own copy of the heat store and the three registers, and
// updates them as each request is accepted.
// Every read request adds the expected pixel to a queue. The checker compares
// each returned pixel with the oldest entry.
// Directed tests cover:
//   - the reset values of the registers;
//   - clear, and function code three (which must be ignored);
//   - landmark coordinates at their extremes, which are clipped;
//   - the largest and smallest radius;
//   - images too small for the window, and images of zero width or height;
//   - reads outside the active image.
// After these, random phases use assorted register settings. Most requests in
// these phases are draws with reads near the landmark, so that the reads see
// pixels the draws have just written.
// Registers are only changed once the unit is idle. A read is used as a
// fence: the engine takes requests in order, so the fence's result arrives
// only after all earlier work is done.
module landmark_heatmap_splatter_unit_tb;
    import lhs_pkg::*;

    localparam logic [1:0] FUNC_NOP   = 2'd3;
    localparam logic [1:0] CFG_SPARE  = 2'd3;
    // The longest correct wait with nothing accepted is a clear or a full-size
    // draw queued behind another. This limit is several times that.
    localparam int         STALL_LIMIT = 300000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_func;
    logic signed [14:0] i_mark_x;
    logic signed [14:0] i_mark_y;
    logic [6:0]         i_read_col;
    logic [6:0]         i_read_row;
    logic               o_valid;
    logic               i_ready;
    logic [15:0]        o_pixel_value;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [7:0]         i_cfg_data;

    landmark_heatmap_splatter_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_mark_x      (i_mark_x),
        .i_mark_y      (i_mark_y),
        .i_read_col    (i_read_col),
        .i_read_row    (i_read_row),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_value (o_pixel_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // The bench's own copy of the unit's state.
    logic [15:0] heat_store [STORE_DEPTH];
    logic [3:0]  radius_reg;
    logic [7:0]  width_reg;
    logic [7:0]  height_reg;
    logic [15:0] pixel_expect_q [$];

    // Integer pixel of the most recent draw, used to aim reads at it.
    int          last_px;
    int          last_py;

    int          err_cnt;
    int          idle_cycles;
    int          burst_left;
    bit          valid_hi;
    // When set, the sender sends without gaps.
    bit          no_gaps;
    // Selects which stall pattern the receiver uses.
    int          stall_mode;
    logic [15:0] stall_pat;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Initial values of all inputs of the unit.
    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_func      = FUNC_CLEAR;
        i_mark_x    = '0;
        i_mark_y    = '0;
        i_read_col  = '0;
        i_read_row  = '0;
        i_ready     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_RADIUS;
        i_cfg_data  = '0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    // Integer square root, taken one bit pair at a time.
    function automatic longint unsigned int_root(input longint unsigned v);
        longint unsigned res;
        longint unsigned bit_w;
        res   = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v   = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w >>= 2;
        end
        return res;
    endfunction

    // Heat value 1/(1+d) in Q1.15, where d is the distance given by the
    // offsets dx and dy in units of 2^-FRAC_BITS.
    function automatic logic [15:0] splat_level(input longint dx, input longint dy);
        longint unsigned q;
        longint unsigned s;
        longint unsigned one_fx;
        longint unsigned den;
        longint unsigned val;
        q      = longint'(dx * dx + dy * dy);
        s      = int_root(q << 16);
        one_fx = 64'd1 << (FRAC_BITS + 8);
        den    = one_fx + s;
        val    = (64'd32768 * one_fx + den / 2) / den;
        if (val > 64'd32768) val = 64'd32768;
        return val[15:0];
    endfunction

    // Clips a landmark coordinate to the range that keeps the window inside
    // an image of the given size. If the image is too small for the window,
    // the upper bound is raised to the lower one.
    function automatic longint clip_mark(input longint v, input longint r, input longint sz);
        longint lo;
        longint hi;
        lo = r << FRAC_BITS;
        hi = (sz - 1 - r) << FRAC_BITS;
        if (hi < lo) hi = lo;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    function automatic int active_w();
        return (width_reg < MAX_WIDTH) ? int'(width_reg) : MAX_WIDTH;
    endfunction

    function automatic int active_h();
        return (height_reg < MAX_HEIGHT) ? int'(height_reg) : MAX_HEIGHT;
    endfunction

    // Splats one landmark into the bench's copy of the store. Each pixel keeps
    // the larger of its old and new values.
    task automatic splat_mark(input longint mx, input longint my);
        longint lx;
        longint ly;
        longint r;
        int     w;
        int     h;
        int     px;
        int     py;
        logic [15:0] lvl;
        w = active_w();
        h = active_h();
        r = radius_reg;
        if (w == 0 || h == 0) return;
        lx = clip_mark(mx, r, w);
        ly = clip_mark(my, r, h);
        last_px = int'(lx >>> FRAC_BITS);
        last_py = int'(ly >>> FRAC_BITS);
        for (py = last_py - int'(r); py <= last_py + int'(r); py++) begin
            if (py < 0 || py >= h) continue;
            for (px = last_px - int'(r); px <= last_px + int'(r); px++) begin
                if (px < 0 || px >= w) continue;
                lvl = splat_level((longint'(px) << FRAC_BITS) - lx,
                                  (longint'(py) << FRAC_BITS) - ly);
                if (lvl > heat_store[py * MAX_WIDTH + px]) begin
                    heat_store[py * MAX_WIDTH + px] = lvl;
                end
            end
        end
    endtask

    // Updates the bench's state for one accepted request. A read also adds
    // its expected pixel to the queue.
    task automatic apply_request(input logic [1:0] func, input logic signed [14:0] mx,
                                 input logic signed [14:0] my, input logic [6:0] col,
                                 input logic [6:0] row);
        case (func)
            FUNC_CLEAR: begin
                foreach (heat_store[k]) heat_store[k] = '0;
            end
            FUNC_DRAW: begin
                splat_mark(longint'(mx), longint'(my));
            end
            FUNC_READ: begin
                if (int'(col) < active_w() && int'(row) < active_h()) begin
                    pixel_expect_q.push_back(heat_store[int'(row) * MAX_WIDTH + int'(col)]);
                end else begin
                    pixel_expect_q.push_back('0);
                end
            end
            default: begin
            end
        endcase
    endtask

    // Sends one request. Unless no_gaps is set, requests go out in bursts of
    // random length with random gaps between them. Within a burst, valid stays
    // high from one request to the next.
    task automatic send_req(input logic [1:0] func, input logic signed [14:0] mx,
                            input logic signed [14:0] my, input logic [6:0] col,
                            input logic [6:0] row);
        if (burst_left <= 0) begin
            if (no_gaps) begin
                burst_left = 1000;
            end else begin
                if (valid_hi) i_valid <= 1'b0;
                valid_hi = 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
        end
        i_valid    <= 1'b1;
        i_func     <= func;
        i_mark_x   <= mx;
        i_mark_y   <= my;
        i_read_col <= col;
        i_read_row <= row;
        valid_hi = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
        apply_request(func, mx, my, col, row);
    endtask

    // Waits until the unit is idle. The fence read's result comes back only
    // after all earlier work is done. The short pause after it lets the read
    // itself finish.
    task automatic wait_idle();
        send_req(FUNC_READ, '0, '0, '0, '0);
        if (valid_hi) i_valid <= 1'b0;
        valid_hi   = 1'b0;
        burst_left = 0;
        while (pixel_expect_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // After each write the write enable is taken low again before the next one, so
    // that consecutive writes never drive the enable twice at one edge.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_RADIUS: radius_reg = data[3:0];
            CFG_WIDTH:  width_reg  = data;
            CFG_HEIGHT: height_reg = data;
            default: begin
            end
        endcase
    endtask

    task automatic set_shape(input logic [7:0] r, input logic [7:0] w, input logic [7:0] h);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    // Reads a pixel near the last landmark. The offset reaches one pixel past
    // the window on each side.
    task automatic read_near();
        int reach;
        reach = int'(radius_reg) + 1;
        send_req(FUNC_READ, '0, '0,
                 7'(last_px + $urandom_range(0, 2 * reach) - reach),
                 7'(last_py + $urandom_range(0, 2 * reach) - reach));
    endtask

    // Picks a landmark coordinate: mostly within or just around the image,
    // sometimes any 15-bit value.
    function automatic logic signed [14:0] pick_mark(input int sz);
        if ($urandom_range(0, 3) == 0) return 15'($urandom);
        return 15'(int'($urandom_range(0, (sz + 4) << FRAC_BITS)) - (2 << FRAC_BITS));
    endfunction

    // The registers must hold their reset values, and after the reset clearing
    // pass the store must read as zero.
    task automatic test_reset_state();
        send_req(FUNC_READ, '0, '0, 7'd0, 7'd0);
        send_req(FUNC_READ, '0, '0, 7'd111, 7'd111);
        // At the reset width of 112, column 112 is outside the image.
        send_req(FUNC_READ, '0, '0, 7'd112, 7'd5);
        send_req(FUNC_DRAW, 15'sd3232, 15'sd1600, '0, '0);
        read_near();
        read_near();
        wait_idle();
    endtask

    // Coordinates at the extremes of their range are clipped to the window.
    // Function code three must have no effect.
    task automatic test_extremes_and_nop();
        send_req(FUNC_DRAW, -15'sd16384, -15'sd16384, '0, '0);
        read_near();
        send_req(FUNC_DRAW, 15'sd16383, 15'sd16383, '0, '0);
        read_near();
        send_req(FUNC_NOP, 15'sd16383, -15'sd1, 7'h7F, 7'h7F);
        send_req(FUNC_READ, '0, '0, 7'd109, 7'd109);
        send_req(FUNC_READ, '0, '0, 7'd2, 7'd2);
        wait_idle();
    endtask

    // After a clear, the pixels read back must be zero.
    task automatic test_clear();
        send_req(FUNC_CLEAR, '0, '0, '0, '0);
        send_req(FUNC_READ, '0, '0, 7'd2, 7'd2);
        send_req(FUNC_READ, '0, '0, 7'd0, 7'd0);
        wait_idle();
    endtask

    // Edge settings: the largest and smallest radius, an image too small for
    // the window, zero width or height, and register values above the store
    // size. Reads outside the active image must return zero.
    task automatic test_edge_settings();
        set_shape(8'd15, 8'd128, 8'd128);
        write_reg(CFG_SPARE, 8'hA5);
        send_req(FUNC_DRAW, 15'sd4000, 15'sd4100, '0, '0);
        read_near();
        send_req(FUNC_READ, '0, '0, 7'd127, 7'd127);
        wait_idle();
        set_shape(8'd0, 8'd255, 8'd200);
        send_req(FUNC_DRAW, 15'sd8191, 15'sd33, '0, '0);
        read_near();
        send_req(FUNC_READ, '0, '0, 7'd127, 7'd0);
        wait_idle();
        // The image is narrower and shorter than the window.
        set_shape(8'd6, 8'd5, 8'd3);
        send_req(FUNC_DRAW, 15'sd100, -15'sd7, '0, '0);
        send_req(FUNC_READ, '0, '0, 7'd4, 7'd2);
        send_req(FUNC_READ, '0, '0, 7'd5, 7'd1);
        send_req(FUNC_READ, '0, '0, 7'd0, 7'd3);
        wait_idle();
        // With zero width or height, a draw writes nothing.
        set_shape(8'd1, 8'd0, 8'd9);
        send_req(FUNC_DRAW, 15'sd64, 15'sd64, '0, '0);
        send_req(FUNC_READ, '0, '0, 7'd1, 7'd1);
        wait_idle();
        set_shape(8'd1, 8'd1, 8'd0);
        send_req(FUNC_DRAW, 15'sd64, 15'sd64, '0, '0);
        send_req(FUNC_READ, '0, '0, 7'd0, 7'd0);
        wait_idle();
    endtask

    // Random phases, each with its own register setting. Each phase
    // mostly draws a landmark and then reads pixels near it. Some phases
    // send without gaps.
    task automatic test_random_phases();
        int n;
        int ph;
        int pick;
        for (ph = 0; ph < 6; ph++) begin
            if (ph == 5) begin
                set_shape(8'd1, 8'd128, 8'd128);
            end else begin
                set_shape(8'($urandom_range(0, 5)), 8'($urandom_range(1, 128)),
                          8'($urandom_range(1, 128)));
            end
            no_gaps = ($urandom_range(0, 2) == 0);
            for (n = 0; n < 80; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 2) begin
                    send_req(FUNC_CLEAR, 15'($urandom), 15'($urandom), 7'($urandom),
                             7'($urandom));
                end else if (pick < 28) begin
                    send_req(FUNC_DRAW, pick_mark(active_w()), pick_mark(active_h()),
                             7'($urandom), 7'($urandom));
                end else if (pick < 80) begin
                    read_near();
                end else if (pick < 95) begin
                    send_req(FUNC_READ, 15'($urandom), 15'($urandom), 7'($urandom),
                             7'($urandom));
                end else begin
                    send_req(FUNC_NOP, 15'($urandom), 15'($urandom), 7'($urandom),
                             7'($urandom));
                end
            end
            no_gaps = 1'b0;
            wait_idle();
        end
    endtask

    // The receiver stalls on one of several patterns: always ready, a rotating
    // 16-bit mask, or ready at random.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 255) == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_pat  <= 16'($urandom);
        end else begin
            stall_pat <= {stall_pat[14:0], stall_pat[15]};
        end
        case (stall_mode)
            0:       i_ready <= 1'b1;
            1:       i_ready <= stall_pat[0];
            default: i_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Checks each returned pixel against the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pixel_expect_q.size() == 0) begin
                report_mismatch($sformatf("pixel %0d returned with none expected",
                                          o_pixel_value));
            end else begin
                if (o_pixel_value !== pixel_expect_q[0]) begin
                    report_mismatch($sformatf("pixel_value got %0d expected %0d",
                                              o_pixel_value, pixel_expect_q[0]));
                end
                void'(pixel_expect_q.pop_front());
            end
        end
    end

    // Watchdog: ends the run if no request is accepted and no result is taken
    // for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        err_cnt     = 0;
        idle_cycles = 0;
        burst_left  = 0;
        valid_hi    = 1'b0;
        no_gaps     = 1'b0;
        stall_mode  = 0;
        stall_pat   = 16'hB3C6;
        last_px     = 0;
        last_py     = 0;
        radius_reg  = 4'd2;
        width_reg   = 8'd112;
        height_reg  = 8'd112;
        foreach (heat_store[k]) heat_store[k] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_extremes_and_nop();
        test_clear();
        test_edge_settings();
        test_random_phases();
        repeat (50) @(posedge i_clk);
        if (err_cnt == 0 && pixel_expect_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
